// File: design/byte_frame_deframer_macros.svh
// Assertion macros for the byte frame deframer.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef BYTE_FRAME_DEFRAMER_MACROS_SVH
`define BYTE_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bfd_pkg.sv
// Shared types and constants of the byte frame deframer.
// No dependencies; used by bfd_ctrl, bfd_dpath and the top level.
package bfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned HDR_BYTES = 3;
  localparam int unsigned LEN_MIN   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_SYMBOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_SYMBOL  = 2'd1;

  localparam logic [BYTE_W-1:0] START_SYMBOL_RST = 8'd126;
  localparam logic [BYTE_W-1:0] TAIL_SYMBOL_RST  = 8'd127;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_HEAD,
    RD_LEN_LO,
    RD_LEN_HI,
    RD_TAIL,
    RD_EMIT
  } rd_sel_t;

  typedef enum logic [1:0] {
    DROP_NONE,
    DROP_ONE,
    DROP_FRAME
  } drop_t;

  typedef struct packed {
    logic    wr_in;
    rd_sel_t rd_sel;
    drop_t   drop;
    logic    load_lo;
    logic    load_len;
    logic    clr_idx;
    logic    inc_idx;
    logic    ld_out;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic fill_lt_hdr;
    logic byte_is_start;
    logic byte_is_tail;
    logic len_bad;
    logic len_short;
    logic idx_is_len;
    logic out_free;
  } status_t;

endpackage

// File: design/bfd_ctrl.sv
// Controller state machine of the byte frame deframer.
// Depends on bfd_pkg; drives commands into bfd_dpath, reads its status.
module bfd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bfd_pkg::status_t sts,
  output bfd_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_CHK0,
    S_CHK1,
    S_CHK2,
    S_CHKT,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.wr_in    = 1'b0;
    cmd.rd_sel   = bfd_pkg::RD_NONE;
    cmd.drop     = bfd_pkg::DROP_NONE;
    cmd.load_lo  = 1'b0;
    cmd.load_len = 1'b0;
    cmd.clr_idx  = 1'b0;
    cmd.inc_idx  = 1'b0;
    cmd.ld_out   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.wr_in = 1'b1;
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        if (sts.fill_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_sel = bfd_pkg::RD_HEAD;
          state_nxt  = S_CHK0;
        end
      end
      S_CHK0: begin
        if (!sts.byte_is_start) begin
          cmd.drop  = bfd_pkg::DROP_ONE;
          state_nxt = S_RD0;
        end else if (sts.fill_lt_hdr) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_sel = bfd_pkg::RD_LEN_LO;
          state_nxt  = S_CHK1;
        end
      end
      S_CHK1: begin
        cmd.load_lo = 1'b1;
        cmd.rd_sel  = bfd_pkg::RD_LEN_HI;
        state_nxt   = S_CHK2;
      end
      S_CHK2: begin
        if (sts.len_bad) begin
          cmd.drop  = bfd_pkg::DROP_ONE;
          state_nxt = S_RD0;
        end else if (sts.len_short) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.load_len = 1'b1;
          cmd.rd_sel   = bfd_pkg::RD_TAIL;
          state_nxt    = S_CHKT;
        end
      end
      S_CHKT: begin
        if (!sts.byte_is_tail) begin
          cmd.drop  = bfd_pkg::DROP_ONE;
          state_nxt = S_RD0;
        end else begin
          cmd.clr_idx = 1'b1;
          state_nxt   = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.rd_sel = bfd_pkg::RD_EMIT;
        state_nxt  = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          if (sts.idx_is_len) begin
            cmd.drop  = bfd_pkg::DROP_FRAME;
            state_nxt = S_RD0;
          end else begin
            cmd.inc_idx = 1'b1;
            state_nxt   = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/bfd_dpath.sv
// Datapath of the byte frame deframer: byte store, head and fill tracking,
// length and symbol checks, output register. Depends on bfd_pkg.
module bfd_dpath #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [bfd_pkg::BYTE_W-1:0]          in_data_byte,
  input  logic                                cfg_we,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfd_pkg::BYTE_W-1:0]          cfg_wdata,
  input  bfd_pkg::cmd_t                       cmd,
  output bfd_pkg::status_t                    sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bfd_pkg::BYTE_W-1:0]          out_byte,
  output logic                                out_first_flag,
  output logic                                out_last_flag
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = ((CW > 16) ? CW : 16) + 1;

  logic [bfd_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [bfd_pkg::BYTE_W-1:0] rdata_r;
  logic [bfd_pkg::BYTE_W-1:0] lo_r;
  logic [bfd_pkg::BYTE_W-1:0] start_r, tail_r;
  logic [bfd_pkg::BYTE_W-1:0] out_byte_r;
  logic                       out_first_r, out_last_r, out_valid_r;
  logic [AW-1:0]              head_r, head_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic [AW-1:0]              len_r;
  logic [AW-1:0]              idx_r;
  logic [AW-1:0]              rd_pos;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic                       rd_en;
  logic [15:0]                len16;
  logic [LW-1:0]              len_ext;
  logic [CW-1:0]              frame_bytes;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW:0]   off);
    logic [AW+1:0] s;
    s = (AW+2)'(base) + (AW+2)'(off);
    if (s >= (AW+2)'(DEPTH)) begin
      s = s - (AW+2)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign len16       = {rdata_r, lo_r};
  assign len_ext     = LW'(len16);
  assign frame_bytes = CW'(len_r) + CW'(1);

  always_comb begin
    case (cmd.rd_sel)
      bfd_pkg::RD_HEAD:   rd_pos = '0;
      bfd_pkg::RD_LEN_LO: rd_pos = AW'(1);
      bfd_pkg::RD_LEN_HI: rd_pos = AW'(2);
      bfd_pkg::RD_TAIL:   rd_pos = len16[AW-1:0];
      bfd_pkg::RD_EMIT:   rd_pos = idx_r;
      default:            rd_pos = '0;
    endcase
  end

  assign rd_en   = (cmd.rd_sel != bfd_pkg::RD_NONE);
  assign rd_addr = wrap_add(head_r, {1'b0, rd_pos});
  assign wr_addr = wrap_add(head_r, (AW+1)'(fill_r));

  always_ff @(posedge clk) begin
    if (cmd.wr_in) begin
      mem[wr_addr] <= in_data_byte;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (cmd.wr_in) begin
      if (fill_r == CW'(DEPTH)) begin
        head_nxt = wrap_add(head_r, (AW+1)'(1));
      end else begin
        fill_nxt = fill_r + CW'(1);
      end
    end else begin
      case (cmd.drop)
        bfd_pkg::DROP_ONE: begin
          head_nxt = wrap_add(head_r, (AW+1)'(1));
          fill_nxt = fill_r - CW'(1);
        end
        bfd_pkg::DROP_FRAME: begin
          head_nxt = wrap_add(head_r, (AW+1)'(frame_bytes));
          fill_nxt = fill_r - frame_bytes;
        end
        default: begin
          head_nxt = head_r;
          fill_nxt = fill_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      start_r     <= bfd_pkg::START_SYMBOL_RST;
      tail_r      <= bfd_pkg::TAIL_SYMBOL_RST;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == bfd_pkg::REG_START_SYMBOL) begin
          start_r <= cfg_wdata;
        end else if (cfg_index == bfd_pkg::REG_TAIL_SYMBOL) begin
          tail_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_lo) begin
      lo_r <= rdata_r;
    end
    if (cmd.load_len) begin
      len_r <= len16[AW-1:0];
    end
    if (cmd.clr_idx) begin
      idx_r <= '0;
    end else if (cmd.inc_idx) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.ld_out) begin
      out_byte_r  <= rdata_r;
      out_first_r <= (idx_r == '0);
      out_last_r  <= (idx_r == len_r);
    end
  end

  assign sts.fill_zero     = (fill_r == '0);
  assign sts.fill_lt_hdr   = (fill_r < CW'(bfd_pkg::HDR_BYTES));
  assign sts.byte_is_start = (rdata_r == start_r);
  assign sts.byte_is_tail  = (rdata_r == tail_r);
  assign sts.len_bad       = (len_ext < LW'(bfd_pkg::LEN_MIN)) || (len_ext >= LW'(DEPTH));
  assign sts.len_short     = (LW'(fill_r) <= len_ext);
  assign sts.idx_is_len    = (idx_r == len_r);
  assign sts.out_free      = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_first_flag = out_first_r;
  assign out_last_flag  = out_last_r;

endmodule

// File: design/byte_frame_deframer.sv
// Byte frame deframer top level. A byte is taken only while the scanner is idle.
// A byte that opens no frame is accepted, read as the head, checked and dropped.
// A full header check reads the head, both length bytes and the tail; emission reads and
// then loads each frame byte, as the byte store has a single registered read port.
// A tail or length failure drops one byte and rescans from the next byte.
// Reset (rst_n low, synchronous) empties the store and restores symbols 126/127.
module byte_frame_deframer #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bfd_pkg::BYTE_W-1:0]    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bfd_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_first_flag,
  output logic                          out_last_flag,
  input  logic                          cfg_we,
  input  logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfd_pkg::BYTE_W-1:0]    cfg_wdata
);

  `include "byte_frame_deframer_macros.svh"

  bfd_pkg::cmd_t    cmd;
  bfd_pkg::status_t sts;

  bfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfd_dpath #(
    .DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data_byte   (in_data_byte),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_first_flag (out_first_flag),
    .out_last_flag  (out_last_flag)
  );

  `BFD_ASSERT_NEXT(a_scan_after_accept, in_valid && !in_stall, in_stall, "no scan after accept")
  `BFD_ASSERT_NOW(a_first_last_excl, out_valid, !(out_first_flag && out_last_flag), "first and last together")
  `BFD_ASSERT_NOW(a_emit_while_busy, $rose(out_valid), in_stall, "word emitted while idle")

endmodule

// File: tb/byte_frame_deframer_test.sv
// Self-checking testbench for byte_frame_deframer: drives link bytes, predicts emitted frame words.
// Depends on bfd_pkg and the byte_frame_deframer RTL; needs no files or arguments.
// Both sides idle and stall at random; the receiver also holds off long enough to back up the input.
module byte_frame_deframer_test;

  localparam int unsigned STORE_DEPTH  = 64;
  localparam int unsigned PTR_W        = $clog2(STORE_DEPTH);
  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_CYCLES = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned MAX_PRINTS   = 100;

  localparam logic [bfd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [bfd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [bfd_pkg::BYTE_W-1:0] data;
    logic                       first;
    logic                       last;
  } frame_word_t;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_stall;
  logic [bfd_pkg::BYTE_W-1:0]    in_data_byte   = '0;
  logic                          out_valid;
  logic                          out_stall      = 1'b0;
  logic [bfd_pkg::BYTE_W-1:0]    out_byte;
  logic                          out_first_flag;
  logic                          out_last_flag;
  logic                          cfg_we         = 1'b0;
  logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
  logic [bfd_pkg::BYTE_W-1:0]    cfg_wdata      = '0;

  // predicted deframer state
  logic [bfd_pkg::BYTE_W-1:0] ring [STORE_DEPTH];
  int unsigned                ring_fill = 0;
  logic [PTR_W-1:0]           ring_head = '0;
  logic [bfd_pkg::BYTE_W-1:0] sym_start = bfd_pkg::START_SYMBOL_RST;
  logic [bfd_pkg::BYTE_W-1:0] sym_tail  = bfd_pkg::TAIL_SYMBOL_RST;

  frame_word_t frame_words_due [$];
  int unsigned errors      = 0;
  int unsigned words_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          steady      = 1'b0;
  int unsigned hold_reqs   = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  byte_frame_deframer #(
    .BUFFER_DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_first_flag(out_first_flag),
    .out_last_flag (out_last_flag),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [bfd_pkg::BYTE_W-1:0] held_at(input int unsigned pos);
    logic [PTR_W-1:0] a;
    a = ring_head + PTR_W'(pos);
    return ring[a];
  endfunction

  task automatic discard(input int unsigned n);
    ring_head = ring_head + PTR_W'(n);
    ring_fill = ring_fill - n;
  endtask

  task automatic deframe_predict(input logic [bfd_pkg::BYTE_W-1:0] b);
    logic [PTR_W-1:0] wr;
    int unsigned      len;
    int unsigned      i;
    bit               scanning;
    if (ring_fill >= STORE_DEPTH) discard(1);
    wr = ring_head + PTR_W'(ring_fill);
    ring[wr] = b;
    ring_fill++;
    scanning = 1'b1;
    while (scanning) begin
      while (ring_fill > 0 && held_at(0) != sym_start) discard(1);
      if (ring_fill < bfd_pkg::HDR_BYTES) begin
        scanning = 1'b0;
      end else begin
        len = 32'({held_at(2), held_at(1)});
        if (len < bfd_pkg::LEN_MIN || len >= STORE_DEPTH) begin
          discard(1);
        end else if (ring_fill < len + 1) begin
          scanning = 1'b0;
        end else if (held_at(len) != sym_tail) begin
          discard(1);
        end else begin
          for (i = 0; i <= len; i++)
            frame_words_due.push_back('{data: held_at(i), first: (i == 0), last: (i == len)});
          discard(len + 1);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string field, input logic [bfd_pkg::BYTE_W-1:0] got,
                                 input logic [bfd_pkg::BYTE_W-1:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch %s: got %02h, want %02h", field, got, want);
  endtask

  always @(posedge clk) begin
    frame_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_words_due.size() == 0) begin
        report_mismatch("word with nothing due", out_byte, '0);
      end else begin
        want = frame_words_due.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
        if (out_first_flag !== want.first)
          report_mismatch("out_first_flag", 8'(out_first_flag), 8'(want.first));
        if (out_last_flag !== want.last)
          report_mismatch("out_last_flag", 8'(out_last_flag), 8'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("byte_frame_deframer test failed");
      $finish;
    end
  end

  task automatic send_word(input logic [bfd_pkg::BYTE_W-1:0] b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    deframe_predict(b);
  endtask

  task automatic send_frame(input logic [15:0] len, input bit tail_ok);
    logic [bfd_pkg::BYTE_W-1:0] t;
    int unsigned                i;
    send_word(sym_start);
    send_word(len[7:0]);
    send_word(len[15:8]);
    for (i = 3; i < len; i++) send_word(8'($urandom_range(255)));
    t = sym_tail;
    while (!tail_ok && t == sym_tail) t = 8'($urandom_range(255));
    send_word(t);
  endtask

  task automatic send_bad_length;
    logic [bfd_pkg::BYTE_W-1:0] lo;
    logic [bfd_pkg::BYTE_W-1:0] hi;
    case ($urandom_range(2))
      0: begin
        lo = 8'($urandom_range(bfd_pkg::LEN_MIN - 1));
        hi = '0;
      end
      1: begin
        lo = 8'($urandom_range(255, STORE_DEPTH));
        hi = '0;
      end
      default: begin
        lo = 8'($urandom_range(255));
        hi = 8'($urandom_range(255, 1));
      end
    endcase
    send_word(sym_start);
    send_word(lo);
    send_word(hi);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (frame_words_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // write both symbols, then both unused indexes, which must change nothing
  task automatic program_symbols(input logic [bfd_pkg::BYTE_W-1:0] start_val,
                                 input logic [bfd_pkg::BYTE_W-1:0] tail_val);
    cfg_we    <= 1'b1;
    cfg_index <= bfd_pkg::REG_START_SYMBOL;
    cfg_wdata <= start_val;
    @(posedge clk);
    sym_start = start_val;
    cfg_index <= bfd_pkg::REG_TAIL_SYMBOL;
    cfg_wdata <= tail_val;
    @(posedge clk);
    sym_tail = tail_val;
    cfg_index <= REG_SPARE_LO;
    cfg_wdata <= 8'($urandom_range(255));
    @(posedge clk);
    cfg_index <= REG_SPARE_HI;
    cfg_wdata <= 8'($urandom_range(255));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_default_symbols;
    send_word(8'h00);
    send_word(8'hFF);
    send_frame(16'd3, 1'b1);
    send_frame(16'd2, 1'b1);
    send_word(sym_start);
    send_word(8'(STORE_DEPTH));
    send_word(8'h00);
    send_word(sym_start);
    send_word(8'h03);
    send_word(8'h01);
    drain();
  endtask

  // tail mismatch on the outer header uncovers two complete inner frames at once
  task automatic test_nested_frames;
    send_word(sym_start);
    send_word(8'd11);
    send_word(8'd0);
    send_word(sym_start);
    send_word(8'd3);
    send_word(8'd0);
    send_word(sym_tail);
    send_word(sym_start);
    send_word(8'd3);
    send_word(8'd0);
    send_word(sym_tail);
    send_word(8'h00);
    drain();
  endtask

  task automatic test_symbol_extremes;
    send_word(sym_start);
    send_word(8'd6);
    send_word(8'd0);
    drain();
    program_symbols(8'h00, 8'hFF);
    send_word(8'h00);
    send_frame(16'd3, 1'b1);
    drain();
    program_symbols(8'hFF, 8'h00);
    send_frame(16'd3, 1'b1);
    drain();
    program_symbols(8'h55, 8'h55);
    send_frame(16'd4, 1'b1);
    drain();
  endtask

  task automatic test_max_length;
    program_symbols(bfd_pkg::START_SYMBOL_RST, bfd_pkg::TAIL_SYMBOL_RST);
    steady = 1'b1;
    send_frame(16'(STORE_DEPTH - 1), 1'b1);
    drain();
    steady = 1'b0;
  endtask

  task automatic test_backpressure;
    hold_reqs++;
    repeat (2) send_frame(16'd5, 1'b1);
    drain();
  endtask

  task automatic test_random_stream(input int unsigned count, input bit run_steady);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned i;
    stop_at = words_sent + count;
    steady  = run_steady;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        if ($urandom_range(99) < 4)
          send_frame(16'($urandom_range(STORE_DEPTH - 1, 13)), 1'b1);
        else
          send_frame(16'($urandom_range(12, bfd_pkg::LEN_MIN)), 1'b1);
      end else if (pick < 77) begin
        send_frame(16'($urandom_range(12, bfd_pkg::LEN_MIN)), 1'b0);
      end else if (pick < 90) begin
        for (i = $urandom_range(4, 1); i > 0; i--) send_word(8'($urandom_range(255)));
      end else begin
        send_bad_length();
      end
    end
    drain();
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_symbols();
    test_nested_frames();
    test_symbol_extremes();
    test_max_length();
    test_backpressure();
    test_random_stream(8, 1'b0);
    program_symbols(8'($urandom_range(255)), 8'($urandom_range(255)));
    test_random_stream(6, 1'b1);
    if (errors == 0)
      $display("byte_frame_deframer test passed");
    else
      $display("byte_frame_deframer test failed");
    $finish;
  end

endmodule

// File: byte_frame_deframer.f
+incdir+design
design/bfd_pkg.sv
design/bfd_ctrl.sv
design/bfd_dpath.sv
design/byte_frame_deframer.sv
tb/byte_frame_deframer_test.sv
